@@ rtl/tempo_step_clock_assert.svh @@
// ---------------------------------------------------------------------------
// tempo_step_clock_assert.svh
// Assertion macros shared by the tempo step clock RTL.
// ---------------------------------------------------------------------------
`ifndef TEMPO_STEP_CLOCK_ASSERT_SVH
`define TEMPO_STEP_CLOCK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tempo_step_clock: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tempo_step_clock: next-cycle check failed");

`endif

@@ rtl/tsc_pkg.sv @@
// ---------------------------------------------------------------------------
// tsc_pkg
// Types and constants of the tempo step clock.
// ---------------------------------------------------------------------------
package tsc_pkg;

  localparam int FRAMES_W   = 16;
  localparam int RATE_W     = 12;
  localparam int RATE_FRAC  = 4;
  localparam int LOOP_W     = 16;
  localparam int SPB_W      = 42;
  localparam int SPS_W      = SPB_W + RATE_FRAC;  // samples_per_beat * 16
  localparam int STEP_W     = 31;
  localparam int PHASE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_CNT_W = 7;                  // holds a divide step count up to 127

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_SYNC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RATE        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BEAT = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPS,
    ST_CUR,
    ST_PHASE,
    ST_PREV,
    ST_WRAP,
    ST_DONE
  } tsc_state_t;

  typedef struct packed {
    logic                  start;
    logic                  sat_mode;
    logic [STEP_CNT_W-1:0] nsteps;
  } tsc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } tsc_div_stat_t;

endpackage

@@ rtl/tsc_div.sv @@
// ---------------------------------------------------------------------------
// tsc_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "tempo_step_clock_assert.svh"

module tsc_div
  import tsc_pkg::*;
#(
  parameter int DVD_W = 64,
  parameter int DIV_W = 46
) (
  input  logic                clk,
  input  logic                rst,
  input  tsc_div_req_t        req,
  input  logic [DVD_W-1:0]    dividend,   // left aligned, MSB first
  input  logic [DIV_W-1:0]    divisor,
  input  logic [DIV_W-1:0]    init_rem,
  output tsc_div_stat_t       stat,
  output logic [DIV_W-1:0]    quotient,
  output logic [DIV_W-1:0]    remainder
);

  localparam int RW = DIV_W + 1;

  logic                  busy;
  logic                  done;
  logic                  sat;
  logic                  sat_mode;
  logic [STEP_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]      dvd;
  logic [RW-1:0]         rem;
  logic [DIV_W-1:0]      quo;
  logic [DIV_W-1:0]      dsr;

  logic [RW-1:0]         rem_sh;
  logic                  ge;
  logic [RW-1:0]         rem_next;
  logic                  frozen;

  always_comb begin
    rem_sh   = {rem[RW-2:0], dvd[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_next = ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
    // in saturating mode, freeze the quotient once it passes the step limit
    frozen   = sat_mode && (sat || quo[STEP_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt      <= req.nsteps;
      sat_mode <= req.sat_mode;
      sat      <= 1'b0;
      dvd      <= dividend;
      rem      <= {1'b0, init_rem};
      quo      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      cnt <= cnt - STEP_CNT_W'(1);
      dvd <= dvd << 1;
      rem <= rem_next;
      if (!frozen) begin
        quo <= {quo[DIV_W-2:0], ge};
      end
      if (sat_mode && quo[STEP_W-1]) begin
        sat <= 1'b1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.sat  = sat;
  assign quotient  = quo;
  assign remainder = rem[DIV_W-1:0];

  `TSC_ASSERT_SAME(a_busy_has_steps, busy, cnt != '0)
  `TSC_ASSERT_NEXT(a_start_busy, req.start, busy)
  `TSC_ASSERT_SAME(a_sat_quo_bound, busy && sat_mode, quo[DIV_W-1:STEP_W] == '0)

endmodule

@@ rtl/tempo_step_clock.sv @@
// Sequence: each item runs the divisions for samples per step, current step and phase;
//   without rewind and while running also the previous step, then the loop wrap when
//   the loop is hit and a step is crossed. A new request is taken only in idle, once
//   the last result is loaded; the single restoring divider, one quotient bit per cycle,
//   runs every division of an item in turn.
// Reset: synchronous; counter cleared, registers to defaults, result register empty.
// ---------------------------------------------------------------------------
// tempo_step_clock
// Musical transport step clock: advances a sample counter per audio block and
// reports step crossings, the current step and the phase within it.
// ---------------------------------------------------------------------------
`include "tempo_step_clock_assert.svh"

module tempo_step_clock
  import tsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // input request
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // frames[15:0], step_rate[27:16], zero
  input  logic                 s_tuser,   // rewind
  // result
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,   // step_index[30:0], current_step[61:31],
                                          // phase[77:62], zero
  output logic                 m_tuser,   // triggered
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPB_W-1:0]     cfg_data
);

  // Dividend register must hold either samples_per_beat*16 or count<<FRAC_BITS.
  localparam int STEP_DVD_W = COUNT_WIDTH + FRAC_BITS;
  localparam int DVD_W      = (STEP_DVD_W > SPS_W) ? STEP_DVD_W : SPS_W;

  localparam logic [STEP_CNT_W-1:0] N_SPS   = STEP_CNT_W'(SPS_W);
  localparam logic [STEP_CNT_W-1:0] N_STEP  = STEP_CNT_W'(STEP_DVD_W);
  localparam logic [STEP_CNT_W-1:0] N_PHASE = STEP_CNT_W'(PHASE_W);
  localparam logic [STEP_CNT_W-1:0] N_WRAP  = STEP_CNT_W'(STEP_W);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic              run_enable;
  logic              external_sync;
  logic              loop_enable;
  logic [LOOP_W-1:0] loop_start;
  logic [LOOP_W-1:0] loop_end;
  logic [RATE_W-1:0] loop_rate;
  logic [SPB_W-1:0]  samples_per_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable       <= 1'b0;
      external_sync    <= 1'b0;
      loop_enable      <= 1'b0;
      loop_start       <= '0;
      loop_end         <= LOOP_W'(16);
      loop_rate        <= RATE_W'(64);
      samples_per_beat <= SPB_W'(1572864000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUN_ENABLE:       run_enable       <= cfg_data[0];
        CFG_EXTERNAL_SYNC:    external_sync    <= cfg_data[0];
        CFG_LOOP_ENABLE:      loop_enable      <= cfg_data[0];
        CFG_LOOP_START:       loop_start       <= cfg_data[LOOP_W-1:0];
        CFG_LOOP_END:         loop_end         <= cfg_data[LOOP_W-1:0];
        CFG_LOOP_RATE:        loop_rate        <= cfg_data[RATE_W-1:0];
        CFG_SAMPLES_PER_BEAT: samples_per_beat <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Sequencer and item registers
  // ------------------------------------------------------------------
  tsc_state_t state, state_next;
  logic       go;

  logic [COUNT_WIDTH-1:0] sample_count;
  logic [FRAMES_W-1:0]    frames;
  logic [RATE_W-1:0]      step_rate;
  logic                   rewind;

  logic [SPS_W-1:0]   sps;
  logic [STEP_W-1:0]  cur;
  logic [SPS_W-1:0]   cur_rem;
  logic [PHASE_W-1:0] phase;
  logic               triggered;
  logic [STEP_W-1:0]  step_index;

  tsc_div_req_t      div_req;
  tsc_div_stat_t     div_stat;
  logic [DVD_W-1:0]  div_dividend;
  logic [SPS_W-1:0]  div_divisor;
  logic [SPS_W-1:0]  div_init_rem;
  logic [SPS_W-1:0]  div_quo;
  logic [SPS_W-1:0]  div_rem;

  logic                   in_accept;
  logic                   out_free;
  logic [FRAMES_W-1:0]    in_frames;
  logic [RATE_W-1:0]      in_rate;
  logic [RATE_W-1:0]      div_rate;
  logic [COUNT_WIDTH-1:0] frames_ext;
  logic [COUNT_WIDTH-1:0] old_pos;
  logic [STEP_W-1:0]      step_res;
  logic                   loop_hit;
  logic                   wrap_ge;
  logic [STEP_W-1:0]      wrap_diff;
  logic [STEP_W-1:0]      wrap_rel;
  logic [STEP_W-1:0]      wrap_idx;

  assign in_frames = s_tdata[FRAMES_W-1:0];
  assign in_rate   = s_tdata[FRAMES_W +: RATE_W];
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    // a zero rate divides as one
    div_rate   = (step_rate == '0) ? RATE_W'(1) : step_rate;
    frames_ext = COUNT_WIDTH'(frames);
    // position before this block, clamped at zero
    old_pos    = (sample_count < frames_ext) ? '0 : (sample_count - frames_ext);
    step_res   = div_stat.sat ? STEP_MAX : div_quo[STEP_W-1:0];
    loop_hit   = loop_enable && (step_rate == loop_rate) && (loop_end > loop_start);
    // loop wrap: remainder of the distance to loop_start, folded to nonnegative
    wrap_ge    = step_index >= STEP_W'(loop_start);
    wrap_diff  = wrap_ge ? (step_index - STEP_W'(loop_start))
                         : (STEP_W'(loop_start) - step_index);
    wrap_rel   = STEP_W'(div_rem[LOOP_W-1:0]);
    if (wrap_ge) begin
      wrap_idx = STEP_W'(loop_start) + wrap_rel;
    end else if (wrap_rel == '0) begin
      wrap_idx = STEP_W'(loop_start);
    end else begin
      wrap_idx = STEP_W'(loop_end) - wrap_rel;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_SPS;
      ST_SPS:   if (div_stat.done) state_next = ST_CUR;
      ST_CUR:   if (div_stat.done) state_next = ST_PHASE;
      ST_PHASE: begin
        if (div_stat.done) begin
          state_next = (!rewind && run_enable) ? ST_PREV : ST_DONE;
        end
      end
      ST_PREV: begin
        if (div_stat.done) begin
          state_next = ((cur > step_res) && loop_hit) ? ST_WRAP : ST_DONE;
        end
      end
      ST_WRAP:  if (div_stat.done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and divider command
  always_comb begin
    s_tready         = 1'b0;
    div_req.start    = go;
    div_req.sat_mode = 1'b0;
    div_req.nsteps   = N_SPS;
    div_dividend     = '0;
    div_divisor      = sps;
    div_init_rem     = '0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SPS: begin
        div_dividend = DVD_W'({samples_per_beat, {RATE_FRAC{1'b0}}}) << (DVD_W - SPS_W);
        div_divisor  = SPS_W'(div_rate);
      end
      ST_CUR: begin
        div_req.sat_mode = 1'b1;
        div_req.nsteps   = N_STEP;
        div_dividend     = DVD_W'(sample_count) << (DVD_W - COUNT_WIDTH);
      end
      ST_PHASE: begin
        div_req.nsteps = N_PHASE;
        div_init_rem   = cur_rem;
      end
      ST_PREV: begin
        div_req.sat_mode = 1'b1;
        div_req.nsteps   = N_STEP;
        div_dividend     = DVD_W'(old_pos) << (DVD_W - COUNT_WIDTH);
      end
      ST_WRAP: begin
        div_req.nsteps = N_WRAP;
        div_dividend   = DVD_W'(wrap_diff) << (DVD_W - STEP_W);
        div_divisor    = SPS_W'(loop_end - loop_start);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // State, divider launch and the counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      go           <= 1'b0;
      sample_count <= '0;
    end else begin
      state <= state_next;
      // launch the divider on entry to each division step
      go    <= (state_next != state) && (state_next != ST_IDLE) && (state_next != ST_DONE);
      if (in_accept) begin
        if (s_tuser) begin
          sample_count <= '0;
        end else if (run_enable && !external_sync) begin
          sample_count <= sample_count + COUNT_WIDTH'(in_frames);
        end
      end
    end
  end

  // Item payload and intermediate results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frames    <= in_frames;
      step_rate <= in_rate;
      rewind    <= s_tuser;
    end
    if (div_stat.done) begin
      unique case (state)
        ST_SPS: sps <= (div_quo == '0) ? SPS_W'(1) : div_quo;
        ST_CUR: begin
          cur     <= step_res;
          cur_rem <= div_rem;
        end
        ST_PHASE: begin
          phase      <= div_quo[PHASE_W-1:0];
          triggered  <= 1'b0;
          step_index <= '0;
        end
        ST_PREV: begin
          if (cur > step_res) begin
            triggered  <= 1'b1;
            step_index <= cur;
          end
        end
        ST_WRAP: step_index <= wrap_idx;
        default: ;
      endcase
    end
  end

  // Result register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {2'b00, phase, cur, step_index};
      m_tuser <= triggered;
    end
  end

  tsc_div #(
    .DVD_W (DVD_W),
    .DIV_W (SPS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .init_rem  (div_init_rem),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  `TSC_ASSERT_NEXT(a_accept_launches, in_accept, state == ST_SPS && div_req.start)
  `TSC_ASSERT_SAME(a_done_in_div_state, div_stat.done, state != ST_IDLE && state != ST_DONE)
  `TSC_ASSERT_SAME(a_sps_nonzero, state == ST_CUR || state == ST_PHASE || state == ST_PREV,
                   sps != '0)
  `TSC_ASSERT_SAME(a_idle_step_zero, m_tvalid && !m_tuser, m_tdata[STEP_W-1:0] == '0)

endmodule
